// ----- rtl/svacc_pkg.sv -----
package svacc_pkg;

  localparam int GRID_SIDE   = 256;
  localparam int SAMPLE_BITS = 16;

  localparam int CFG_INDEX_W = 2;
  localparam int CFG_DATA_W  = 11;

  localparam logic [1:0] CMD_PLOT = 2'd0;
  localparam logic [1:0] CMD_FADE = 2'd1;
  localparam logic [1:0] CMD_READ = 2'd2;
  localparam logic [1:0] CMD_NONE = 2'd3;

  localparam logic [1:0] MODE_ROT   = 2'd0;
  localparam logic [1:0] MODE_XY    = 2'd1;
  localparam logic [1:0] MODE_POLAR = 2'd2;
  localparam logic [1:0] MODE_SPARE = 2'd3;  // decodes as polar

  localparam logic [1:0] REG_MODE = 2'd0;
  localparam logic [1:0] REG_ZOOM = 2'd1;
  localparam logic [1:0] REG_MONO = 2'd2;

  typedef logic [1:0] op_t;
  localparam op_t OP_PLOT = 2'd0;
  localparam op_t OP_FADE = 2'd1;
  localparam op_t OP_READ = 2'd2;

  typedef struct packed {
    logic [7:0] alpha;
    logic [7:0] blue;
    logic [7:0] green;
    logic [7:0] red;
  } pixel_t;

  typedef struct packed {
    logic start;
    op_t  op;
  } store_req_t;

  typedef struct packed {
    logic ready;
    logic done;
  } store_resp_t;

endpackage

// ----- rtl/svacc_in_if.sv -----
interface svacc_in_if #(
  parameter int SAMPLE_BITS = svacc_pkg::SAMPLE_BITS
);
  logic                          valid;
  logic                          ready;
  logic [1:0]                    cmd;
  logic signed [SAMPLE_BITS-1:0] left_sample;
  logic signed [SAMPLE_BITS-1:0] right_sample;
  logic [7:0]                    read_x;
  logic [7:0]                    read_y;

  modport source (output valid, cmd, left_sample, right_sample, read_x, read_y, input ready);
  modport sink (input valid, cmd, left_sample, right_sample, read_x, read_y, output ready);
endinterface

// ----- rtl/svacc_out_if.sv -----
interface svacc_out_if;
  logic       valid;
  logic       ready;
  logic [1:0] result_kind;
  logic [7:0] pixel_x;
  logic [7:0] pixel_y;
  logic [7:0] red;
  logic [7:0] green;
  logic [7:0] blue;
  logic [7:0] alpha;

  modport source (output valid, result_kind, pixel_x, pixel_y, red, green, blue, alpha,
                  input ready);
  modport sink (input valid, result_kind, pixel_x, pixel_y, red, green, blue, alpha,
                output ready);
endinterface

// ----- rtl/svacc_cfg_if.sv -----
interface svacc_cfg_if;
  logic                               valid;
  logic                               ready;
  logic [svacc_pkg::CFG_INDEX_W-1:0] index;
  logic [svacc_pkg::CFG_DATA_W-1:0]  data;

  modport source (output valid, index, data, input ready);
  modport sink (input valid, index, data, output ready);
endinterface

// ----- rtl/svacc_isqrt.sv -----
module svacc_isqrt (
  input  logic        clk,
  input  logic        rst,
  input  logic        start,
  input  logic [32:0] rad,
  output logic        done,
  output logic [16:0] root
);

  logic [4:0]  k;
  logic        busy;
  logic [16:0] t;
  logic [33:0] tsq;

  always_comb begin
    t   = root | (17'd1 << k);
    tsq = 34'(t) * 34'(t);
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      busy <= 1'b0;
      done <= 1'b0;
      k    <= '0;
    end else begin
      done <= !start && busy && (k == 5'd0);
      if (start) begin
        busy <= 1'b1;
        k    <= 5'd16;
        root <= '0;
      end else if (busy) begin
        if (tsq <= 34'(rad)) root <= t;
        if (k == 5'd0) begin
          busy <= 1'b0;
        end else begin
          k <= k - 5'd1;
        end
      end
    end
  end

endmodule

// ----- rtl/svacc_map.sv -----
module svacc_map #(
  parameter int GRID_SIDE   = svacc_pkg::GRID_SIDE,
  parameter int SAMPLE_BITS = svacc_pkg::SAMPLE_BITS
) (
  input  logic                           clk,
  input  logic                           rst,
  input  logic                           start,
  input  logic signed [SAMPLE_BITS-1:0]  s1,
  input  logic signed [SAMPLE_BITS-1:0]  s2,
  input  logic [1:0]                     mode,
  input  logic [10:0]                    zoom,
  output logic                           done,
  output logic [$clog2(GRID_SIDE)-1:0]   x,
  output logic [$clog2(GRID_SIDE)-1:0]   y
);

  localparam int SB   = SAMPLE_BITS;
  localparam int F    = SB - 1;
  localparam int CW   = $clog2(GRID_SIDE);
  localparam int HW   = GRID_SIDE / 2;
  localparam int PW   = SB + 13;
  localparam int QW   = 21;
  localparam int SQW  = 42;
  localparam int XW   = 39;
  localparam int NW   = SB + 24;
  localparam int NXW  = (NW > 52) ? NW : 52;
  localparam int Q1W  = NXW - 32;
  localparam int DW   = $clog2(10 * GRID_SIDE);
  localparam int MW   = DW + 16;
  localparam int TSH  = F + 8 - 16;
  localparam int TSR  = (TSH > 0) ? TSH : 0;
  localparam int TSL  = (TSH < 0) ? -TSH : 0;
  localparam int SH0  = F + 9;
  localparam int SH1  = F + 8;
  localparam longint ONE32 = longint'(1) << 32;
  localparam longint D10   = longint'(10) * ONE32;
  localparam longint C0    = longint'(HW) * (longint'(1) << SH0);
  localparam longint C1    = longint'(HW) * (longint'(1) << SH1);

  localparam logic [3:0] M_IDLE  = 4'd0;
  localparam logic [3:0] M_MUL   = 4'd1;
  localparam logic [3:0] M_LIN   = 4'd2;
  localparam logic [3:0] M_Q     = 4'd3;
  localparam logic [3:0] M_SQ    = 4'd4;
  localparam logic [3:0] M_RS    = 4'd5;
  localparam logic [3:0] M_ROOT  = 4'd6;
  localparam logic [3:0] M_CROSS = 4'd7;
  localparam logic [3:0] M_SUM   = 4'd8;
  localparam logic [3:0] M_NUM   = 4'd9;
  localparam logic [3:0] M_OUT   = 4'd10;

  logic [3:0] state;
  logic signed [SB-1:0]  rs1, rs2;
  logic signed [PW-1:0]  p1, p2;
  logic signed [QW-1:0]  sx, sy;
  logic [32:0]           rad_x, rad_y;
  logic signed [XW-1:0]  cx, cy, sum, diff;
  logic signed [NXW-1:0] nx, ny;

  logic signed [SB:0]    a, b;
  logic signed [11:0]    zs;
  logic signed [QW-1:0]  tx, ty;
  logic signed [SQW:0]   rx_full, ry_full;
  logic signed [XW-1:0]  tsel, mag;
  logic [16:0]           root_x, root_y;
  logic                  root_done, root_done_y;
  logic [CW-1:0]         x_next, y_next;

  function automatic logic signed [QW-1:0] to_q16(input logic signed [PW-1:0] p);
    logic signed [PW-1:0] q;
    q = (p < 0) ? (p + PW'((longint'(1) << TSR) - 1)) >>> TSR : p >>> TSR;
    return QW'(q <<< TSL);
  endfunction

  function automatic logic signed [SQW:0] radicand(input logic signed [QW-1:0] s);
    logic signed [SQW-1:0] sq;
    sq = SQW'(s) * SQW'(s);
    return (SQW+1)'(ONE32) - (SQW+1)'(sq >>> 1);
  endfunction

  function automatic logic [CW-1:0] lin_coord(input logic signed [NXW-1:0] n,
                                              input logic sel0);
    logic signed [NXW-1:0] q;
    q = sel0 ? (n >>> SH0) : (n >>> SH1);
    if (n < 0) return '0;
    if (q > NXW'(GRID_SIDE - 1)) return CW'(GRID_SIDE - 1);
    return CW'(q);
  endfunction

  function automatic logic [CW-1:0] pol_coord(input logic signed [NXW-1:0] n);
    logic [Q1W-1:0] q1;
    logic [MW-1:0]  prod;
    q1   = Q1W'(n >>> 32);
    prod = MW'(q1) * MW'(52429);
    if (n < 0) return '0;
    if (q1 >= Q1W'(10 * GRID_SIDE)) return CW'(GRID_SIDE - 1);
    return CW'(prod >> 19);
  endfunction

  always_comb begin
    zs      = $signed({1'b0, zoom});
    a       = (mode == svacc_pkg::MODE_ROT) ? (SB+1)'(rs2) - (SB+1)'(rs1) : (SB+1)'(rs2);
    b       = (mode == svacc_pkg::MODE_ROT) ? (SB+1)'(rs1) + (SB+1)'(rs2) : (SB+1)'(rs1);
    tx      = to_q16(p1);
    ty      = to_q16(p2);
    rx_full = radicand(sx);
    ry_full = radicand(sy);
    tsel    = (sum > 0) ? diff : ((sum < 0) ? -diff : '0);
    mag     = (sum < 0) ? -sum : sum;
    if (mode == svacc_pkg::MODE_ROT || mode == svacc_pkg::MODE_XY) begin
      x_next = lin_coord(nx, mode == svacc_pkg::MODE_ROT);
      y_next = lin_coord(ny, mode == svacc_pkg::MODE_ROT);
    end else begin
      x_next = pol_coord(nx);
      y_next = pol_coord(ny);
    end
  end

  svacc_isqrt u_root_y (
    .clk  (clk),
    .rst  (rst),
    .start(state == M_RS),
    .rad  (rad_y),
    .done (root_done),
    .root (root_y)
  );

  svacc_isqrt u_root_x (
    .clk  (clk),
    .rst  (rst),
    .start(state == M_RS),
    .rad  (rad_x),
    .done (root_done_y),
    .root (root_x)
  );

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= M_IDLE;
      done  <= 1'b0;
    end else begin
      done <= (state == M_OUT);
      unique case (state)
        M_IDLE: begin
          if (start) begin
            rs1   <= s1;
            rs2   <= s2;
            state <= M_MUL;
          end
        end
        M_MUL: begin
          p1    <= PW'(a) * PW'(zs);
          p2    <= PW'(b) * PW'(zs);
          state <= (mode == svacc_pkg::MODE_ROT || mode == svacc_pkg::MODE_XY) ? M_LIN : M_Q;
        end
        M_LIN: begin
          if (mode == svacc_pkg::MODE_ROT) begin
            nx <= NXW'(p1) * NXW'(HW) + NXW'(C0);
            ny <= NXW'(C0) - NXW'(p2) * NXW'(HW);
          end else begin
            nx <= NXW'(p1) * NXW'(HW) + NXW'(C1);
            ny <= NXW'(p2) * NXW'(HW) + NXW'(C1);
          end
          state <= M_OUT;
        end
        M_Q: begin
          sx    <= tx;
          sy    <= ty;
          state <= M_SQ;
        end
        M_SQ: begin
          rad_x <= (rx_full < 0) ? '0 : 33'(rx_full);
          rad_y <= (ry_full < 0) ? '0 : 33'(ry_full);
          state <= M_RS;
        end
        M_RS: state <= M_ROOT;
        M_ROOT: begin
          if (root_done && root_done_y) state <= M_CROSS;
        end
        M_CROSS: begin
          cx    <= XW'(sx) * XW'($signed({1'b0, root_y}));
          cy    <= XW'(sy) * XW'($signed({1'b0, root_x}));
          state <= M_SUM;
        end
        M_SUM: begin
          sum   <= cx + cy;
          diff  <= cx - cy;
          state <= M_NUM;
        end
        M_NUM: begin
          nx    <= NXW'(longint'(HW) * D10) + NXW'(HW * 7) * NXW'(tsel);
          ny    <= NXW'(longint'(GRID_SIDE) * D10) - NXW'(GRID_SIDE * 7) * NXW'(mag);
          state <= M_OUT;
        end
        M_OUT: begin
          x     <= x_next;
          y     <= y_next;
          state <= M_IDLE;
        end
        default: state <= M_IDLE;
      endcase
    end
  end

  a_root_pair: assert property (@(posedge clk) disable iff (rst)
    root_done == root_done_y)
    else $error("square root lanes out of step");

endmodule

// ----- rtl/svacc_store.sv -----
module svacc_store #(
  parameter int GRID_SIDE = svacc_pkg::GRID_SIDE
) (
  input  logic                          clk,
  input  logic                          rst,
  input  svacc_pkg::store_req_t         req,
  input  logic [$clog2(GRID_SIDE)-1:0]  x,
  input  logic [$clog2(GRID_SIDE)-1:0]  y,
  output svacc_pkg::store_resp_t        resp,
  output svacc_pkg::pixel_t             pix
);

  localparam int DEPTH = GRID_SIDE * GRID_SIDE;
  localparam int AW    = $clog2(DEPTH);
  localparam logic [AW-1:0] LAST = AW'(DEPTH - 1);

  localparam logic [2:0] S_CLEAR    = 3'd0;
  localparam logic [2:0] S_IDLE     = 3'd1;
  localparam logic [2:0] S_PLOT_RD  = 3'd2;
  localparam logic [2:0] S_PLOT_WR  = 3'd3;
  localparam logic [2:0] S_READ_RD  = 3'd4;
  localparam logic [2:0] S_READ_WR  = 3'd5;
  localparam logic [2:0] S_FADE     = 3'd6;
  localparam logic [2:0] S_FADE_END = 3'd7;

  svacc_pkg::pixel_t mem [DEPTH];
  svacc_pkg::pixel_t rdata, wd;
  logic [2:0]    state;
  logic [AW-1:0] addr, count, fade_wa, ra, wa;
  logic          fade_wr, we, done;

  function automatic logic [7:0] sat_add(input logic [7:0] c, input logic [7:0] k);
    logic [8:0] s;
    s = {1'b0, c} + {1'b0, k};
    return s[8] ? 8'hFF : s[7:0];
  endfunction

  function automatic logic [7:0] sat_sub64(input logic [7:0] c);
    return (c > 8'd64) ? c - 8'd64 : 8'd0;
  endfunction

  always_comb begin
    ra = (state == S_FADE) ? count : addr;
    we = 1'b0;
    wa = addr;
    wd = rdata;
    unique case (state)
      S_CLEAR: begin
        we = 1'b1;
        wa = count;
        wd = '0;
      end
      S_PLOT_WR: begin
        we       = 1'b1;
        wd.red   = sat_add(rdata.red, 8'd30);
        wd.green = sat_add(rdata.green, 8'd50);
        wd.blue  = sat_add(rdata.blue, 8'd30);
        wd.alpha = 8'hFF;
      end
      S_FADE, S_FADE_END: begin
        we       = fade_wr;
        wa       = fade_wa;
        wd.red   = sat_sub64(rdata.red);
        wd.green = sat_sub64(rdata.green);
        wd.blue  = sat_sub64(rdata.blue);
        wd.alpha = sat_sub64(rdata.alpha);
      end
      default: ;
    endcase
  end

  always_ff @(posedge clk) begin
    if (we) mem[wa] <= wd;
    rdata <= mem[ra];
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state   <= S_CLEAR;
      count   <= '0;
      fade_wr <= 1'b0;
      done    <= 1'b0;
    end else begin
      done <= (state == S_PLOT_WR) || (state == S_READ_WR) || (state == S_FADE_END);
      unique case (state)
        S_CLEAR: begin
          if (count == LAST) begin
            count <= '0;
            state <= S_IDLE;
          end else begin
            count <= count + AW'(1);
          end
        end
        S_IDLE: begin
          if (req.start) begin
            addr    <= AW'(y) * AW'(GRID_SIDE) + AW'(x);
            fade_wr <= 1'b0;
            unique case (req.op)
              svacc_pkg::OP_PLOT: state <= S_PLOT_RD;
              svacc_pkg::OP_READ: state <= S_READ_RD;
              svacc_pkg::OP_FADE: state <= S_FADE;
              default:            state <= S_IDLE;
            endcase
          end
        end
        S_PLOT_RD: state <= S_PLOT_WR;
        S_PLOT_WR: begin
          pix   <= wd;
          state <= S_IDLE;
        end
        S_READ_RD: state <= S_READ_WR;
        S_READ_WR: begin
          pix   <= rdata;
          state <= S_IDLE;
        end
        S_FADE: begin
          fade_wr <= 1'b1;
          fade_wa <= count;
          if (count == LAST) begin
            count <= '0;
            state <= S_FADE_END;
          end else begin
            count <= count + AW'(1);
          end
        end
        S_FADE_END: begin
          fade_wr <= 1'b0;
          pix     <= '0;
          state   <= S_IDLE;
        end
        default: state <= S_IDLE;
      endcase
    end
  end

  always_comb begin
    resp.ready = (state == S_IDLE);
    resp.done  = done;
  end

  a_idle_no_write: assert property (@(posedge clk) disable iff (rst)
    state == S_IDLE |-> !we)
    else $error("memory write while idle");

  a_plot_done: assert property (@(posedge clk) disable iff (rst)
    state == S_PLOT_WR |=> resp.done)
    else $error("plot write without completion");

  a_idle_count: assert property (@(posedge clk) disable iff (rst)
    state == S_IDLE |-> count == '0)
    else $error("walk counter not parked at zero");

endmodule

// ----- rtl/stereo_vectorscope_accumulator.sv -----
// channel     dir  payload
// sample_in   in   cmd, left_sample, right_sample, read_x, read_y
// result_out  out  result_kind, pixel_x, pixel_y, red, green, blue, alpha
// cfg         in   index, data (0 mode, 1 zoom, 2 mono_input)
//
// Plot: the mapper, then a store read and write; polar mode adds a
// 17-step square root. Read and Fade go straight to the store.
// sample_in.ready returns the cycle after the result register loads.
// After reset a clearing pass writes every pixel, with sample_in.ready low;
// cfg is always ready.
// A word waiting on result_out does not stop the next word from being taken;
// that word's result then waits, with sample_in.ready low, until it drains.
module stereo_vectorscope_accumulator #(
  parameter int GRID_SIDE   = svacc_pkg::GRID_SIDE,
  parameter int SAMPLE_BITS = svacc_pkg::SAMPLE_BITS
) (
  input  logic         clk,
  input  logic         rst,
  svacc_in_if.sink     sample_in,
  svacc_out_if.source  result_out,
  svacc_cfg_if.sink    cfg
);

  localparam int CW = $clog2(GRID_SIDE);

  localparam logic [1:0] T_IDLE  = 2'd0;
  localparam logic [1:0] T_MAP   = 2'd1;
  localparam logic [1:0] T_STORE = 2'd2;
  localparam logic [1:0] T_HOLD  = 2'd3;

  logic [1:0]  state;
  logic [1:0]  mode;
  logic [10:0] zoom;
  logic        mono_input;

  logic [1:0]    kind;
  logic [CW-1:0] hx, hy, rx, ry, map_x, map_y, st_x, st_y;
  svacc_pkg::pixel_t     st_pix;
  svacc_pkg::store_req_t  st_req;
  svacc_pkg::store_resp_t st_resp;
  logic accept, map_done, out_free;
  logic signed [SAMPLE_BITS-1:0] s2;

  assign sample_in.ready = (state == T_IDLE) && st_resp.ready;
  assign accept   = sample_in.valid && sample_in.ready;
  assign cfg.ready = 1'b1;
  assign out_free = !result_out.valid || result_out.ready;
  assign s2 = mono_input ? sample_in.left_sample : sample_in.right_sample;

  always_comb begin
    rx = (int'(sample_in.read_x) > GRID_SIDE - 1) ? CW'(GRID_SIDE - 1) : CW'(sample_in.read_x);
    ry = (int'(sample_in.read_y) > GRID_SIDE - 1) ? CW'(GRID_SIDE - 1) : CW'(sample_in.read_y);
    st_req.start = map_done ||
                   (accept && (sample_in.cmd == svacc_pkg::CMD_FADE ||
                               sample_in.cmd == svacc_pkg::CMD_READ));
    st_req.op    = map_done ? svacc_pkg::OP_PLOT :
                   (sample_in.cmd == svacc_pkg::CMD_FADE) ? svacc_pkg::OP_FADE :
                   svacc_pkg::OP_READ;
    st_x = map_done ? map_x : rx;
    st_y = map_done ? map_y : ry;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      mode       <= svacc_pkg::MODE_ROT;
      zoom       <= 11'd256;
      mono_input <= 1'b0;
    end else if (cfg.valid && cfg.ready) begin
      case (cfg.index)
        svacc_pkg::REG_MODE: mode       <= cfg.data[1:0];
        svacc_pkg::REG_ZOOM: zoom       <= cfg.data;
        svacc_pkg::REG_MONO: mono_input <= cfg.data[0];
        default: ;
      endcase
    end
  end

  svacc_map #(
    .GRID_SIDE  (GRID_SIDE),
    .SAMPLE_BITS(SAMPLE_BITS)
  ) u_map (
    .clk  (clk),
    .rst  (rst),
    .start(accept && sample_in.cmd == svacc_pkg::CMD_PLOT),
    .s1   (sample_in.left_sample),
    .s2   (s2),
    .mode (mode),
    .zoom (zoom),
    .done (map_done),
    .x    (map_x),
    .y    (map_y)
  );

  svacc_store #(
    .GRID_SIDE(GRID_SIDE)
  ) u_store (
    .clk (clk),
    .rst (rst),
    .req (st_req),
    .x   (st_x),
    .y   (st_y),
    .resp(st_resp),
    .pix (st_pix)
  );

  always_ff @(posedge clk) begin
    if (rst) begin
      state            <= T_IDLE;
      result_out.valid <= 1'b0;
    end else begin
      if (result_out.valid && result_out.ready && state != T_HOLD) result_out.valid <= 1'b0;
      unique case (state)
        T_IDLE: begin
          if (accept) begin
            kind <= sample_in.cmd;
            hx   <= (sample_in.cmd == svacc_pkg::CMD_READ) ? rx : '0;
            hy   <= (sample_in.cmd == svacc_pkg::CMD_READ) ? ry : '0;
            case (sample_in.cmd)
              svacc_pkg::CMD_PLOT: state <= T_MAP;
              svacc_pkg::CMD_NONE: state <= T_IDLE;
              default:             state <= T_STORE;
            endcase
          end
        end
        T_MAP: begin
          if (map_done) begin
            hx    <= map_x;
            hy    <= map_y;
            state <= T_STORE;
          end
        end
        T_STORE: begin
          if (st_resp.done) state <= T_HOLD;
        end
        T_HOLD: begin
          if (out_free) begin
            result_out.valid       <= 1'b1;
            result_out.result_kind <= kind;
            result_out.pixel_x     <= 8'(hx);
            result_out.pixel_y     <= 8'(hy);
            result_out.red         <= st_pix.red;
            result_out.green       <= st_pix.green;
            result_out.blue        <= st_pix.blue;
            result_out.alpha       <= st_pix.alpha;
            state                  <= T_IDLE;
          end
        end
        default: state <= T_IDLE;
      endcase
    end
  end

  a_map_in_map: assert property (@(posedge clk) disable iff (rst)
    map_done |-> state == T_MAP)
    else $error("mapper finished outside plot sequence");

endmodule

// ----- verif/stereo_vectorscope_accumulator_tb.sv -----
`timescale 1ns / 1ps

module stereo_vectorscope_accumulator_tb;

  localparam int GRID_SIDE   = svacc_pkg::GRID_SIDE;
  localparam int SAMPLE_BITS = svacc_pkg::SAMPLE_BITS;
  localparam int HALF = GRID_SIDE / 2;
  localparam longint CYCLE_LIMIT = 3000000;

  typedef struct {
    logic [1:0] kind;
    logic [7:0] x;
    logic [7:0] y;
    svacc_pkg::pixel_t pix;
  } plot_result_t;

  logic clk;
  logic rst;

  svacc_in_if  sin();
  svacc_out_if sout();
  svacc_cfg_if scfg();

  stereo_vectorscope_accumulator dut (
    .clk        (clk),
    .rst        (rst),
    .sample_in  (sin),
    .result_out (sout),
    .cfg        (scfg)
  );

  bit [31:0]    canvas [GRID_SIDE*GRID_SIDE];
  plot_result_t pending [$];
  logic [1:0]   cur_mode;
  logic [10:0]  cur_zoom;
  logic         cur_mono;
  int           errors;
  int           checked;
  int           n_plot, n_fade, n_read, n_skip;
  longint       cycles;
  bit           calm;
  int           stall_left;
  logic [7:0]   last_x, last_y;

  always begin
    clk = 1'b1;
    #10;
    clk = 1'b0;
    #10;
  end

  always @(posedge clk) begin
    cycles <= cycles + 1;
    if (cycles > CYCLE_LIMIT) begin
      $display("timeout after %0d cycles, %0d words pending", cycles, pending.size());
      $display("FAIL");
      $finish;
    end
  end

  always @(posedge clk) begin
    if (rst) begin
      sout.ready <= 1'b1;
      stall_left <= 0;
    end else if (stall_left > 0) begin
      sout.ready <= 1'b0;
      stall_left <= stall_left - 1;
    end else begin
      sout.ready <= 1'b1;
      if (!calm && $urandom_range(0, 9) == 0)
        stall_left <= int'($urandom_range(1, 16));
    end
  end

  task automatic report(string what, int got, int want);
    $display("mismatch %s: got %0d expected %0d (word %0d)", what, got, want, checked);
    errors++;
  endtask

  always @(posedge clk) begin
    plot_result_t e;
    if (!rst && sout.valid && sout.ready) begin
      if (pending.size() == 0) begin
        report("unexpected word kind", int'(sout.result_kind), -1);
      end else begin
        e = pending.pop_front();
        if (sout.result_kind !== e.kind)
          report("result_kind", int'(sout.result_kind), int'(e.kind));
        if (sout.pixel_x !== e.x) report("pixel_x", int'(sout.pixel_x), int'(e.x));
        if (sout.pixel_y !== e.y) report("pixel_y", int'(sout.pixel_y), int'(e.y));
        if (sout.red !== e.pix.red) report("red", int'(sout.red), int'(e.pix.red));
        if (sout.green !== e.pix.green)
          report("green", int'(sout.green), int'(e.pix.green));
        if (sout.blue !== e.pix.blue) report("blue", int'(sout.blue), int'(e.pix.blue));
        if (sout.alpha !== e.pix.alpha)
          report("alpha", int'(sout.alpha), int'(e.pix.alpha));
      end
      checked++;
    end
  end

  function automatic longint root_q32(longint r);
    longint res;
    longint b;
    longint t;
    res = 0;
    b = longint'(1) << 16;
    if (r <= 0) return 0;
    while (b > 0) begin
      t = res + b;
      if (t * t <= r) res = t;
      b = b >>> 1;
    end
    return res;
  endfunction

  function automatic int clamp_grid(longint v);
    if (v < 0) return 0;
    if (v > GRID_SIDE - 1) return GRID_SIDE - 1;
    return int'(v);
  endfunction

  function automatic void map_to_grid(longint s1, longint s2, output int px, output int py);
    longint z, d, x, y, sx, sy, rx, ry, cx, cy, sum, diff, sg, mag, one;
    z = longint'(cur_zoom);
    if (cur_mode == svacc_pkg::MODE_ROT) begin
      d = longint'(1) << (SAMPLE_BITS - 1 + 9);
      x = ((s2 - s1) * z * HALF + HALF * d) / d;
      y = (HALF * d - (s1 + s2) * z * HALF) / d;
    end else if (cur_mode == svacc_pkg::MODE_XY) begin
      d = longint'(1) << (SAMPLE_BITS - 1 + 8);
      x = (s2 * z * HALF + HALF * d) / d;
      y = (s1 * z * HALF + HALF * d) / d;
    end else begin
      one = longint'(1) << 32;
      sx = (s2 * z) / (longint'(1) << (SAMPLE_BITS - 1 + 8 - 16));
      sy = (s1 * z) / (longint'(1) << (SAMPLE_BITS - 1 + 8 - 16));
      ry = root_q32(one - (sy * sy) / 2);
      rx = root_q32(one - (sx * sx) / 2);
      cx = sx * ry;
      cy = sy * rx;
      sum = cx + cy;
      diff = cx - cy;
      sg = (sum > 0) ? 1 : ((sum < 0) ? -1 : 0);
      mag = (sum < 0) ? -sum : sum;
      d = 10 * one;
      x = (HALF * d + sg * HALF * 7 * diff) / d;
      y = (GRID_SIDE * d - GRID_SIDE * 7 * mag) / d;
    end
    px = clamp_grid(x);
    py = clamp_grid(y);
  endfunction

  function automatic int add_sat(int c, int k);
    return (c + k > 255) ? 255 : c + k;
  endfunction

  function automatic int sub_sat(int c);
    return (c > 64) ? c - 64 : 0;
  endfunction

  function automatic void apply_word(logic [1:0] cmd, logic signed [15:0] l,
                                     logic signed [15:0] r, logic [7:0] rx, logic [7:0] ry);
    plot_result_t e;
    int px, py, idx;
    svacc_pkg::pixel_t p;
    longint s1, s2;
    if (cmd == svacc_pkg::CMD_PLOT) begin
      s1 = longint'(l);
      s2 = cur_mono ? s1 : longint'(r);
      map_to_grid(s1, s2, px, py);
      idx = py * GRID_SIDE + px;
      p = canvas[idx];
      p.red = 8'(add_sat(int'(p.red), 30));
      p.green = 8'(add_sat(int'(p.green), 50));
      p.blue = 8'(add_sat(int'(p.blue), 30));
      p.alpha = 8'd255;
      canvas[idx] = p;
      e.kind = svacc_pkg::CMD_PLOT; e.x = 8'(px); e.y = 8'(py); e.pix = p;
      last_x = 8'(px); last_y = 8'(py);
      n_plot++;
      pending.push_back(e);
    end else if (cmd == svacc_pkg::CMD_FADE) begin
      for (int i = 0; i < GRID_SIDE * GRID_SIDE; i++) begin
        p = canvas[i];
        p.red = 8'(sub_sat(int'(p.red)));
        p.green = 8'(sub_sat(int'(p.green)));
        p.blue = 8'(sub_sat(int'(p.blue)));
        p.alpha = 8'(sub_sat(int'(p.alpha)));
        canvas[i] = p;
      end
      e.kind = svacc_pkg::CMD_FADE; e.x = '0; e.y = '0; e.pix = '0;
      n_fade++;
      pending.push_back(e);
    end else if (cmd == svacc_pkg::CMD_READ) begin
      e.kind = svacc_pkg::CMD_READ; e.x = rx; e.y = ry;
      e.pix = canvas[int'(ry) * GRID_SIDE + int'(rx)];
      n_read++;
      pending.push_back(e);
    end else begin
      n_skip++;
    end
  endfunction

  // caller sits at a rising edge; returns at the accepting edge with valid still high
  task automatic send_word(logic [1:0] cmd, logic [15:0] l, logic [15:0] r,
                           logic [7:0] rx, logic [7:0] ry);
    if (!calm && $urandom_range(0, 4) == 0) begin
      sin.valid <= 1'b0;
      repeat ($urandom_range(1, 16)) @(posedge clk);
    end
    sin.valid <= 1'b1;
    sin.cmd <= cmd;
    sin.left_sample <= l;
    sin.right_sample <= r;
    sin.read_x <= rx;
    sin.read_y <= ry;
    @(posedge clk);
    while (!sin.ready) @(posedge clk);
    apply_word(cmd, l, r, rx, ry);
  endtask

  task automatic drain(int extra);
    sin.valid <= 1'b0;
    @(posedge clk);
    while (pending.size() != 0) @(posedge clk);
    repeat (extra) @(posedge clk);
  endtask

  task automatic set_regs(logic [1:0] m, logic [10:0] z, logic mono);
    drain(60);
    scfg.valid <= 1'b1;
    scfg.index <= svacc_pkg::REG_MODE;
    scfg.data <= 11'(m);
    @(posedge clk);
    while (!scfg.ready) @(posedge clk);
    cur_mode = m;
    scfg.index <= svacc_pkg::REG_ZOOM;
    scfg.data <= z;
    @(posedge clk);
    while (!scfg.ready) @(posedge clk);
    cur_zoom = z;
    scfg.index <= svacc_pkg::REG_MONO;
    scfg.data <= 11'(mono);
    @(posedge clk);
    while (!scfg.ready) @(posedge clk);
    cur_mono = mono;
    scfg.valid <= 1'b0;
    @(posedge clk);
  endtask

  function automatic logic [15:0] pick_sample();
    case ($urandom_range(0, 5))
      0: return 16'h8000;
      1: return 16'h7fff;
      2: return 16'($signed($urandom_range(0, 2047)) - 1024);
      default: return 16'($urandom);
    endcase
  endfunction

  task automatic test_directed();
    set_regs(svacc_pkg::MODE_ROT, 11'd256, 1'b0);
    send_word(svacc_pkg::CMD_PLOT, 16'h0000, 16'h0000, 8'd0, 8'd0);
    send_word(svacc_pkg::CMD_PLOT, 16'h7fff, 16'h8000, 8'd0, 8'd0);
    send_word(svacc_pkg::CMD_PLOT, 16'h8000, 16'h7fff, 8'd0, 8'd0);
    send_word(svacc_pkg::CMD_PLOT, 16'h7fff, 16'h7fff, 8'd0, 8'd0);
    send_word(svacc_pkg::CMD_PLOT, 16'h8000, 16'h8000, 8'd0, 8'd0);
    repeat (6) send_word(svacc_pkg::CMD_PLOT, 16'h0000, 16'h0000, 8'd0, 8'd0);
    send_word(svacc_pkg::CMD_READ, 16'h0, 16'h0, 8'(HALF), 8'(HALF));
    send_word(svacc_pkg::CMD_READ, 16'hffff, 16'hffff, 8'd255, 8'd255);
    send_word(svacc_pkg::CMD_READ, 16'h0, 16'h0, 8'd0, 8'd0);
    send_word(svacc_pkg::CMD_NONE, 16'hffff, 16'hffff, 8'hff, 8'hff);
    send_word(svacc_pkg::CMD_FADE, 16'h0, 16'h0, 8'd0, 8'd0);
    send_word(svacc_pkg::CMD_READ, 16'h0, 16'h0, 8'(HALF), 8'(HALF));
    set_regs(svacc_pkg::MODE_POLAR, 11'd1024, 1'b1);
    send_word(svacc_pkg::CMD_PLOT, 16'h7fff, 16'h1234, 8'd0, 8'd0);
    send_word(svacc_pkg::CMD_PLOT, 16'h8000, 16'h0000, 8'd0, 8'd0);
    send_word(svacc_pkg::CMD_PLOT, 16'h0000, 16'h0000, 8'd0, 8'd0);
    set_regs(svacc_pkg::MODE_SPARE, 11'd0, 1'b0);
    send_word(svacc_pkg::CMD_PLOT, 16'h7fff, 16'h8000, 8'd0, 8'd0);
    set_regs(svacc_pkg::MODE_SPARE, 11'd2047, 1'b0);
    send_word(svacc_pkg::CMD_PLOT, 16'h4000, 16'hc000, 8'd0, 8'd0);
    send_word(svacc_pkg::CMD_PLOT, 16'h7fff, 16'h7fff, 8'd0, 8'd0);
  endtask

  task automatic run_burst(int count);
    int k;
    for (int i = 0; i < count; i++) begin
      k = $urandom_range(0, 99);
      if (k < 62)
        send_word(svacc_pkg::CMD_PLOT, pick_sample(), pick_sample(), 8'($urandom),
                  8'($urandom));
      else if (k < 85)
        send_word(svacc_pkg::CMD_READ, 16'($urandom), 16'($urandom), last_x, last_y);
      else if (k < 96)
        send_word(svacc_pkg::CMD_READ, 16'($urandom), 16'($urandom), 8'($urandom),
                  8'($urandom));
      else
        send_word(svacc_pkg::CMD_NONE, 16'($urandom), 16'($urandom), 8'($urandom),
                  8'($urandom));
    end
  endtask

  task automatic test_settings();
    logic [10:0] zooms [6] = '{11'd128, 11'd1024, 11'd256, 11'd0, 11'd2047, 11'd384};
    for (int m = 0; m < 4; m++) begin
      for (int j = 0; j < 3; j++) begin
        set_regs(2'(m), zooms[(m + j * 2) % 6], 1'(j == 1));
        run_burst(110);
      end
    end
  endtask

  task automatic test_random_with_fades();
    for (int f = 0; f < 2; f++) begin
      set_regs(2'($urandom_range(0, 3)), 11'($urandom_range(128, 1024)), 1'($urandom));
      run_burst(120);
      send_word(svacc_pkg::CMD_FADE, 16'($urandom), 16'($urandom), 8'($urandom),
                8'($urandom));
      run_burst(40);
      drain(0);
    end
  endtask

  task automatic test_calm();
    calm = 1'b1;
    set_regs(2'($urandom_range(0, 3)), 11'($urandom_range(128, 1024)), 1'($urandom));
    run_burst(120);
    set_regs(svacc_pkg::MODE_ROT, 11'($urandom_range(0, 2047)), 1'b0);
    run_burst(100);
  endtask

  initial begin
    errors = 0; checked = 0; cycles = 0; calm = 1'b0;
    n_plot = 0; n_fade = 0; n_read = 0; n_skip = 0;
    last_x = 8'(HALF); last_y = 8'(HALF);
    cur_mode = svacc_pkg::MODE_ROT; cur_zoom = 11'd256; cur_mono = 1'b0;
    for (int i = 0; i < GRID_SIDE * GRID_SIDE; i++) canvas[i] = '0;
    rst <= 1'b1;
    sin.valid <= 1'b0; sin.cmd <= svacc_pkg::CMD_PLOT; sin.left_sample <= '0;
    sin.right_sample <= '0; sin.read_x <= '0; sin.read_y <= '0;
    scfg.valid <= 1'b0; scfg.index <= svacc_pkg::REG_MODE; scfg.data <= '0;
    repeat (12) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);
    test_directed();
    test_settings();
    test_random_with_fades();
    test_calm();
    drain(80);
    $display("covered %0d plots, %0d reads, %0d fades, %0d ignored words", n_plot, n_read,
             n_fade, n_skip);
    $display("all mapping modes incl. mode 3, zoom 0..2047, mono on/off; %0d words checked",
             checked);
    if (errors == 0) begin
      $display("PASS");
    end else begin
      $display("FAIL");
    end
    $finish;
  end

endmodule

// ----- stereo_vectorscope_accumulator.f -----
rtl/svacc_pkg.sv
rtl/svacc_in_if.sv
rtl/svacc_out_if.sv
rtl/svacc_cfg_if.sv
rtl/svacc_isqrt.sv
rtl/svacc_map.sv
rtl/svacc_store.sv
rtl/stereo_vectorscope_accumulator.sv
verif/stereo_vectorscope_accumulator_tb.sv
